@@ rtl/bqd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad TDF-II package
// Widths, register map, sequencer states and saturation helpers shared by
// the biquad filter unit.
// ----------------------------------------------------------------------------
package bqd_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W   = 24;                   // Q1.23 samples
  localparam int COEF_W     = 32;                   // Q4.28 coefficients
  localparam int STATE_W    = 32;                   // Q9.23 delay states
  localparam int DATA_W     = 32;                   // register port data
  localparam int ADDR_W     = 5;                    // seven 32-bit registers
  localparam int IDX_W      = 3;                    // register index bits
  localparam int PROD_W     = SAMPLE_W + COEF_W;    // exact Q.51 product
  localparam int FRAC_SHIFT = 28;                   // Q.51 to Q.23
  localparam int ACC_W      = STATE_W + FRAC_SHIFT + 2;
  localparam int RND_W      = ACC_W - FRAC_SHIFT;   // rounded sum width

  // Reset value of b0 is 1.0 in Q4.28.
  localparam logic [COEF_W-1:0] COEF_B0_RESET = 32'h1000_0000;

  // Register map, one index per 32-bit word.
  typedef enum logic [IDX_W-1:0] {
    REG_COEF_B0     = 3'd0,
    REG_COEF_B1     = 3'd1,
    REG_COEF_B2     = 3'd2,
    REG_COEF_A1     = 3'd3,
    REG_COEF_A2     = 3'd4,
    REG_INIT_FIRST  = 3'd5,
    REG_INIT_SECOND = 3'd6
  } reg_idx_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ACC_Y  = 6'b000010,
    ST_MUL_A1 = 6'b000100,
    ST_MUL_B2 = 6'b001000,
    ST_MUL_A2 = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  // Saturate a rounded sum to the 24-bit sample range.
  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [RND_W-1:0] v);
    logic neg;
    logic [SAMPLE_W-1:0] res;
    neg = v[RND_W-1];
    if (neg && !(&v[RND_W-2:SAMPLE_W-1])) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else if (!neg && (|v[RND_W-2:SAMPLE_W-1])) begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // Saturate a rounded sum to the 32-bit state range.
  function automatic logic [STATE_W-1:0] sat_state(input logic [RND_W-1:0] v);
    logic neg;
    logic [STATE_W-1:0] res;
    neg = v[RND_W-1];
    if (neg && !(&v[RND_W-2:STATE_W-1])) begin
      res = {1'b1, {(STATE_W-1){1'b0}}};
    end else if (!neg && (|v[RND_W-2:STATE_W-1])) begin
      res = {1'b0, {(STATE_W-1){1'b1}}};
    end else begin
      res = v[STATE_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/biquad_tdf2_filter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad TDF-II filter unit
// Second-order IIR section in transposed direct form II. One shared
// 24x32 signed multiplier and one accumulator adder run five
// multiply-accumulates per sample under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                          Direction
//  --------  ---------------------------------------------  ---------
//  input     in_valid, in_ready, in_sample_in, in_block_end   in
//  result    out_valid, out_ready, out_sample_out,            out
//            out_state_first_out, out_state_second_out,
//            out_block_end_out
//  config    psel, penable, pwrite, paddr, pwdata,            in/out
//            prdata, pready
//
//  A new sample is accepted only in ST_IDLE, not while the sequence runs:
//  the one shared multiplier handles the five coefficient products in turn.
//  The result register is loaded from ST_FIN, after the steps ST_ACC_Y
//  to ST_MUL_A2, and holds the result until taken; the next input beat
//  can be taken meanwhile. If the result register is still full at the
//  last step, the sequencer waits there until out_ready frees it.
//  Reset (rst_n low, synchronous) sets b0 to 1.0, the other registers and
//  both delay states to zero, and empties the result register.
//
module biquad_tdf2_filter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bqd_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                in_block_end,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bqd_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic signed [bqd_pkg::STATE_W-1:0]  out_state_first_out,
  output logic signed [bqd_pkg::STATE_W-1:0]  out_state_second_out,
  output logic                                out_block_end_out,
  // Register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bqd_pkg::ADDR_W-1:0]          paddr,
  input  logic [bqd_pkg::DATA_W-1:0]          pwdata,
  output logic [bqd_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int SW = bqd_pkg::SAMPLE_W;
  localparam int CW = bqd_pkg::COEF_W;
  localparam int TW = bqd_pkg::STATE_W;
  localparam int PW = bqd_pkg::PROD_W;
  localparam int AW = bqd_pkg::ACC_W;
  localparam int FS = bqd_pkg::FRAC_SHIFT;

  // Configuration registers.
  logic [CW-1:0] coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;
  logic [TW-1:0] init_first_r, init_second_r;

  // Filter state.
  logic [TW-1:0] delay_first_r, delay_first_nxt;
  logic [TW-1:0] delay_second_r, delay_second_nxt;

  // Sequencer and datapath registers.
  bqd_pkg::state_t state_r, state_nxt;
  logic [SW-1:0] x_r, x_nxt;
  logic [SW-1:0] y_r, y_nxt;
  logic [TW-1:0] s1_r, s1_nxt;
  logic          end_r, end_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [AW-1:0] acc_r, acc_nxt;

  // Result register.
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_y_r, out_y_nxt;
  logic [TW-1:0] out_s1_r, out_s1_nxt;
  logic [TW-1:0] out_s2_r, out_s2_nxt;
  logic          out_end_r, out_end_nxt;

  // Shared arithmetic signals.
  logic signed [SW-1:0]   mul_a;
  logic signed [CW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  logic [AW-1:0]          prod_ext;
  logic [AW-1:0]          add_a;
  logic                   add_sub;
  logic [AW-1:0]          sum;
  logic [bqd_pkg::RND_W-1:0] sum_rnd;
  logic [bqd_pkg::RND_W-1:0] acc_rnd;

  logic in_fire;
  logic fin_go;
  logic cfg_wr;
  bqd_pkg::reg_idx_t cfg_idx;

  assign in_ready  = (state_r == bqd_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign fin_go    = (state_r == bqd_pkg::ST_FIN) && (!out_valid_r || out_ready);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_idx   = bqd_pkg::reg_idx_t'(paddr[bqd_pkg::ADDR_W-1:2]);
  assign pready    = 1'b1;

  // Register reads.
  always_comb begin
    unique case (cfg_idx)
      bqd_pkg::REG_COEF_B0:     prdata = coef_b0_r;
      bqd_pkg::REG_COEF_B1:     prdata = coef_b1_r;
      bqd_pkg::REG_COEF_B2:     prdata = coef_b2_r;
      bqd_pkg::REG_COEF_A1:     prdata = coef_a1_r;
      bqd_pkg::REG_COEF_A2:     prdata = coef_a2_r;
      bqd_pkg::REG_INIT_FIRST:  prdata = init_first_r;
      bqd_pkg::REG_INIT_SECOND: prdata = init_second_r;
      default:                  prdata = '0;
    endcase
  end

  // Coefficient and initial-state register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r     <= bqd_pkg::COEF_B0_RESET;
      coef_b1_r     <= '0;
      coef_b2_r     <= '0;
      coef_a1_r     <= '0;
      coef_a2_r     <= '0;
      init_first_r  <= '0;
      init_second_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bqd_pkg::REG_COEF_B0:     coef_b0_r     <= pwdata;
        bqd_pkg::REG_COEF_B1:     coef_b1_r     <= pwdata;
        bqd_pkg::REG_COEF_B2:     coef_b2_r     <= pwdata;
        bqd_pkg::REG_COEF_A1:     coef_a1_r     <= pwdata;
        bqd_pkg::REG_COEF_A2:     coef_a2_r     <= pwdata;
        bqd_pkg::REG_INIT_FIRST:  init_first_r  <= pwdata;
        bqd_pkg::REG_INIT_SECOND: init_second_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Multiplier operand selection: the sample on entry, then x or y.
  always_comb begin
    unique case (state_r)
      bqd_pkg::ST_IDLE: begin
        mul_a = in_sample_in;
        mul_b = coef_b0_r;
      end
      bqd_pkg::ST_ACC_Y: begin
        mul_a = x_r;
        mul_b = coef_b1_r;
      end
      bqd_pkg::ST_MUL_A1: begin
        mul_a = y_r;
        mul_b = coef_a1_r;
      end
      bqd_pkg::ST_MUL_B2: begin
        mul_a = x_r;
        mul_b = coef_b2_r;
      end
      bqd_pkg::ST_MUL_A2: begin
        mul_a = y_r;
        mul_b = coef_a2_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = coef_b2_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Accumulator adder: the registered product is added or subtracted.
  assign prod_ext = {{(AW-PW){prod_r[PW-1]}}, prod_r};

  always_comb begin
    add_a   = acc_r;
    add_sub = 1'b0;
    unique case (state_r)
      bqd_pkg::ST_MUL_B2: add_sub = 1'b1;
      bqd_pkg::ST_FIN:    add_sub = 1'b1;
      bqd_pkg::ST_MUL_A2: add_a   = {{(AW-FS){1'b0}}, 1'b1, {(FS-1){1'b0}}};
      default: ;
    endcase
  end

  assign sum     = add_sub ? (add_a - prod_ext) : (add_a + prod_ext);
  // Floor shift by 28; the rounding half LSB is already in the accumulator.
  assign sum_rnd = sum[AW-1:FS];
  assign acc_rnd = acc_r[AW-1:FS];

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt        = state_r;
    x_nxt            = x_r;
    y_nxt            = y_r;
    s1_nxt           = s1_r;
    end_nxt          = end_r;
    prod_nxt         = prod_r;
    acc_nxt          = acc_r;
    delay_first_nxt  = delay_first_r;
    delay_second_nxt = delay_second_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_y_nxt        = out_y_r;
    out_s1_nxt       = out_s1_r;
    out_s2_nxt       = out_s2_r;
    out_end_nxt      = out_end_r;

    unique case (state_r)
      bqd_pkg::ST_IDLE: begin
        if (in_fire) begin
          x_nxt     = in_sample_in;
          end_nxt   = in_block_end;
          prod_nxt  = mul_p;
          // s1 aligned to Q.51 with the rounding half LSB in the empty bits.
          acc_nxt   = {{2{delay_first_r[TW-1]}}, delay_first_r, 1'b1, {(FS-1){1'b0}}};
          state_nxt = bqd_pkg::ST_ACC_Y;
        end
      end
      bqd_pkg::ST_ACC_Y: begin
        y_nxt     = bqd_pkg::sat_sample(sum_rnd);
        prod_nxt  = mul_p;
        acc_nxt   = {{2{delay_second_r[TW-1]}}, delay_second_r, 1'b1, {(FS-1){1'b0}}};
        state_nxt = bqd_pkg::ST_MUL_A1;
      end
      bqd_pkg::ST_MUL_A1: begin
        prod_nxt  = mul_p;
        acc_nxt   = sum;
        state_nxt = bqd_pkg::ST_MUL_B2;
      end
      bqd_pkg::ST_MUL_B2: begin
        prod_nxt  = mul_p;
        acc_nxt   = sum;
        state_nxt = bqd_pkg::ST_MUL_A2;
      end
      bqd_pkg::ST_MUL_A2: begin
        // The first state sum is complete; start the second with b2*x.
        s1_nxt    = bqd_pkg::sat_state(acc_rnd);
        prod_nxt  = mul_p;
        acc_nxt   = sum;
        state_nxt = bqd_pkg::ST_FIN;
      end
      bqd_pkg::ST_FIN: begin
        if (fin_go) begin
          delay_first_nxt  = s1_r;
          delay_second_nxt = bqd_pkg::sat_state(sum_rnd);
          out_valid_nxt    = 1'b1;
          out_y_nxt        = y_r;
          out_s1_nxt       = s1_r;
          out_s2_nxt       = bqd_pkg::sat_state(sum_rnd);
          out_end_nxt      = end_r;
          state_nxt        = bqd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bqd_pkg::ST_IDLE;
    endcase

    // Initial-state writes load the delays; the user must write them between samples, the block does not enforce it.
    if (cfg_wr && (cfg_idx == bqd_pkg::REG_INIT_FIRST)) begin
      delay_first_nxt = pwdata;
    end
    if (cfg_wr && (cfg_idx == bqd_pkg::REG_INIT_SECOND)) begin
      delay_second_nxt = pwdata;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= bqd_pkg::ST_IDLE;
      out_valid_r    <= 1'b0;
      delay_first_r  <= '0;
      delay_second_r <= '0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      delay_first_r  <= delay_first_nxt;
      delay_second_r <= delay_second_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    s1_r     <= s1_nxt;
    end_r    <= end_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    out_y_r  <= out_y_nxt;
    out_s1_r <= out_s1_nxt;
    out_s2_r <= out_s2_nxt;
    out_end_r <= out_end_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_sample_out       = out_y_r;
  assign out_state_first_out  = out_s1_r;
  assign out_state_second_out = out_s2_r;
  assign out_block_end_out    = out_end_r;

  // An accepted input beat always starts the product sequence.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == bqd_pkg::ST_ACC_Y)
    else $error("accepted beat did not start the sequence");

  // A new result appears only from the last sequencer step.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == bqd_pkg::ST_FIN))
    else $error("result appeared outside the final step");

  // A full, stalled result register holds the sequencer at its last step.
  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bqd_pkg::ST_FIN && out_valid && !out_ready
      |=> state_r == bqd_pkg::ST_FIN)
    else $error("final step overran a waiting result");

endmodule
